[src/tid_pkg.sv]
// Shared types and constants for the TIM image pixel decoder.
package tid_pkg;

	// Image kinds as held by the parser and carried with each pixel job.
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_16   = 2'd1,
		KIND_8    = 2'd2,
		KIND_4    = 2'd3
	} kind_t;

	localparam logic [31:0] TYPE_DIRECT = 32'h0000_0002;
	localparam logic [31:0] TYPE_8BPP   = 32'h0000_0009;
	localparam logic [31:0] TYPE_4BPP   = 32'h0000_0008;

	localparam logic [14:0] COLOUR_MASK = 15'h7fff;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

	// Register addresses on the configuration port.
	localparam logic [2:0] ADDR_TRANSPARENT_BLACK = 3'd0;

	typedef struct packed {
		logic [15:0] word;
		logic        start_of_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_of_run;
		logic       last_of_image;
	} pixel_t;

	// One data word handed from the parser to the pixel expander.
	typedef struct packed {
		logic        valid;
		logic [15:0] word;
		kind_t       kind;
		logic        last;
	} job_t;

endpackage

[src/tid_parser.sv]
// Header parser: walks the file structure and fills the palette.
module tid_parser #(
	parameter int PALETTE_DEPTH = 256,
	parameter int PAW = $clog2(PALETTE_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  tid_pkg::in_item_t item,
	output tid_pkg::job_t     job,
	output logic              wr_en,
	output logic [PAW-1:0]    wr_addr,
	output logic [15:0]       wr_data
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_MAGIC,
		PH_TYPE,
		PH_CLUT_HDR,
		PH_CLUT_DATA,
		PH_DSIZE,
		PH_IMG_HDR,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	phase_t          phase_q, phase_n;
	logic [3:0]      hwc_q, hwc_n;
	tid_pkg::kind_t  kind_q, kind_n;
	logic [15:0]     total_q, total_n;
	logic [15:0]     fill_q, fill_n;
	logic [15:0]     row_q, row_n;
	logic [31:0]     remain_q, remain_n;
	logic [15:0]     type_low_q, type_low_n;
	logic [31:0]     type_full;
	logic            last_word;

	assign type_full = {item.word, type_low_q};
	assign last_word = (remain_q <= 32'd1);
	assign wr_addr   = fill_q[PAW-1:0];
	assign wr_data   = item.word;

	always_comb begin
		phase_n    = phase_q;
		hwc_n      = hwc_q;
		kind_n     = kind_q;
		total_n    = total_q;
		fill_n     = fill_q;
		row_n      = row_q;
		remain_n   = remain_q;
		type_low_n = type_low_q;
		wr_en      = 1'b0;
		job.valid  = 1'b0;
		job.word   = item.word;
		job.kind   = kind_q;
		job.last   = last_word;
		if (accept) begin
			if (item.start_of_file) begin
				phase_n  = PH_MAGIC;
				hwc_n    = 4'd1;
				kind_n   = tid_pkg::KIND_NONE;
				total_n  = '0;
				fill_n   = '0;
				row_n    = '0;
				remain_n = '0;
			end else begin
				case (phase_q)
					PH_MAGIC: begin
						phase_n = PH_TYPE;
						hwc_n   = 4'd0;
					end
					PH_TYPE: begin
						if (hwc_q == 4'd0) begin
							type_low_n = item.word;
							hwc_n      = 4'd1;
						end else begin
							hwc_n = 4'd0;
							if (type_full == tid_pkg::TYPE_DIRECT) begin
								kind_n  = tid_pkg::KIND_16;
								phase_n = PH_DSIZE;
							end else if (type_full == tid_pkg::TYPE_8BPP) begin
								kind_n  = tid_pkg::KIND_8;
								phase_n = PH_CLUT_HDR;
							end else if (type_full == tid_pkg::TYPE_4BPP) begin
								kind_n  = tid_pkg::KIND_4;
								phase_n = PH_CLUT_HDR;
							end else begin
								kind_n  = tid_pkg::KIND_NONE;
								phase_n = PH_DSIZE;
							end
						end
					end
					PH_CLUT_HDR: begin
						if (hwc_q == 4'd4)
							total_n = item.word;
						if (hwc_q == 4'd5) begin
							hwc_n   = 4'd0;
							fill_n  = '0;
							phase_n = (total_q == 16'd0) ? PH_DSIZE : PH_CLUT_DATA;
						end else begin
							hwc_n = hwc_q + 4'd1;
						end
					end
					PH_CLUT_DATA: begin
						// Entries beyond the palette are consumed but not stored.
						wr_en  = ({1'b0, fill_q} < 17'(PALETTE_DEPTH));
						fill_n = fill_q + 16'd1;
						if (fill_n >= total_q) begin
							phase_n = PH_DSIZE;
							hwc_n   = 4'd0;
						end
					end
					PH_DSIZE: begin
						if (hwc_q == 4'd0) begin
							hwc_n = 4'd1;
						end else begin
							hwc_n   = 4'd0;
							phase_n = PH_IMG_HDR;
						end
					end
					PH_IMG_HDR: begin
						if (hwc_q == 4'd2)
							row_n = item.word;
						if (hwc_q == 4'd3) begin
							hwc_n    = 4'd0;
							remain_n = 32'(row_q) * 32'(item.word);
							if (kind_q == tid_pkg::KIND_NONE || row_q == 16'd0 ||
								item.word == 16'd0)
								phase_n = PH_DONE;
							else
								phase_n = PH_PIXELS;
						end else begin
							hwc_n = hwc_q + 4'd1;
						end
					end
					PH_PIXELS: begin
						job.valid = 1'b1;
						remain_n  = last_word ? 32'd0 : remain_q - 32'd1;
						if (last_word)
							phase_n = PH_DONE;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hwc_q      <= '0;
			kind_q     <= tid_pkg::KIND_NONE;
			total_q    <= '0;
			fill_q     <= '0;
			row_q      <= '0;
			remain_q   <= '0;
			type_low_q <= '0;
		end else begin
			phase_q    <= phase_n;
			hwc_q      <= hwc_n;
			kind_q     <= kind_n;
			total_q    <= total_n;
			fill_q     <= fill_n;
			row_q      <= row_n;
			remain_q   <= remain_n;
			type_low_q <= type_low_n;
		end
	end

endmodule

[src/tid_expander.sv]
// Pixel expander: palette memory, per-pixel lookup and RGBA output register.
module tid_expander #(
	parameter int PALETTE_DEPTH = 256,
	parameter int PAW = $clog2(PALETTE_DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            transparent_black,
	input  tid_pkg::job_t   job,
	output logic            job_ready,
	input  logic            wr_en,
	input  logic [PAW-1:0]  wr_addr,
	input  logic [15:0]     wr_data,
	output logic            pix_valid,
	input  logic            pix_ready,
	output tid_pkg::pixel_t pix_data
);

	logic [15:0] palette_mem [PALETTE_DEPTH];

	// Job held while its pixels are looked up, one per cycle unless the lookup stage is stalled.
	logic           job_valid_q;
	logic [15:0]    word_s1;
	tid_pkg::kind_t kind_s1;
	logic           last_s1;
	logic [1:0]     sub_q;
	logic [1:0]     last_sub;
	logic [7:0]     index;
	logic           issue;
	logic           job_done;

	// Lookup stage: registered palette data and pixel flags.
	logic           valid_s2;
	logic [15:0]    pal_s2;
	logic [15:0]    direct_s2;
	logic           is_direct_s2;
	logic           oob_s2;
	logic           run_end_s2;
	logic           img_end_s2;
	logic           adv_s2;
	logic [15:0]    colour;

	logic            out_valid_q;
	tid_pkg::pixel_t out_q;
	logic            out_en;

	always_comb begin
		case (kind_s1)
			tid_pkg::KIND_8: last_sub = 2'd1;
			tid_pkg::KIND_4: last_sub = 2'd3;
			default:         last_sub = 2'd0;
		endcase
	end

	always_comb begin
		case (kind_s1)
			tid_pkg::KIND_8: index = sub_q[0] ? word_s1[15:8] : word_s1[7:0];
			tid_pkg::KIND_4: index = {4'd0, word_s1[4*sub_q +: 4]};
			default:         index = '0;
		endcase
	end

	assign out_en    = !out_valid_q || pix_ready;
	assign adv_s2    = !valid_s2 || out_en;
	assign issue     = job_valid_q && adv_s2;
	assign job_done  = issue && (sub_q == last_sub);
	assign job_ready = !job_valid_q || job_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			sub_q       <= '0;
		end else if (job_ready) begin
			job_valid_q <= job.valid;
			sub_q       <= '0;
		end else if (issue) begin
			sub_q <= sub_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready) begin
			word_s1 <= job.word;
			kind_s1 <= job.kind;
			last_s1 <= job.last;
		end
	end

	// The last lookup of a job reads before any palette write of the next word.
	always_ff @(posedge clk) begin
		if (wr_en)
			palette_mem[wr_addr] <= wr_data;
		if (issue)
			pal_s2 <= palette_mem[index[PAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s2)
			valid_s2 <= issue;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			direct_s2    <= word_s1;
			is_direct_s2 <= (kind_s1 == tid_pkg::KIND_16);
			oob_s2       <= ({1'b0, index} >= 9'(PALETTE_DEPTH));
			run_end_s2   <= (sub_q == last_sub);
			img_end_s2   <= (sub_q == last_sub) && last_s1;
		end
	end

	assign colour = is_direct_s2 ? direct_s2 : (oob_s2 ? 16'd0 : pal_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_en)
			out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			out_q.red   <= {colour[4:0], 3'b000};
			out_q.green <= {colour[9:5], 3'b000};
			out_q.blue  <= {colour[14:10], 3'b000};
			if (colour == 16'd0 ||
				(transparent_black && (colour[14:0] & tid_pkg::COLOUR_MASK) == 15'd0))
				out_q.alpha <= 8'd0;
			else
				out_q.alpha <= tid_pkg::ALPHA_OPAQUE;
			out_q.last_of_run   <= run_end_s2;
			out_q.last_of_image <= img_end_s2;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix_data  = out_q;

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (sub_q <= last_sub))
		else $error("pixel counter ran past the end of its word");

	a_done_reaches_s2: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |=> (valid_s2 && run_end_s2))
		else $error("last lookup of a word did not reach the lookup stage");

	a_image_end_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last_of_image) |-> out_q.last_of_run)
		else $error("end of image without end of run");

	a_alpha_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.alpha == 8'd0 || out_q.alpha == tid_pkg::ALPHA_OPAQUE))
		else $error("alpha neither transparent nor opaque");

endmodule

[src/tim_image_pixel_decoder.sv]
// Top level of the TIM image pixel decoder with its configuration register.
// Takes a TIM file one 16-bit word per handshake and emits one RGBA pixel per output
// word. Header, colour-table and 15-bit direct-colour words are taken one per cycle
// while the output is not stalled; an 8-bit indexed word holds the input until both of
// its pixels are looked up and a 4-bit one until all four are (one palette read port,
// one lookup per pixel). A word's pixels pass the job register, the lookup stage and
// the output register, which lets the next word be taken while a finished pixel waits.
// The palette needs no clearing after reset, so the block is ready at once.
module tim_image_pixel_decoder #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              src_valid,
	output logic              src_ready,
	input  tid_pkg::in_item_t src_data,
	output logic              pix_valid,
	input  logic              pix_ready,
	output tid_pkg::pixel_t   pix_data
);

	localparam int PAW = $clog2(PALETTE_DEPTH);

	logic           transparent_black_q;
	logic           accept;
	tid_pkg::job_t  job;
	logic           wr_en;
	logic [PAW-1:0] wr_addr;
	logic [15:0]    wr_data;

	assign pready = 1'b1;
	assign prdata = (paddr == tid_pkg::ADDR_TRANSPARENT_BLACK) ?
		{31'd0, transparent_black_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			transparent_black_q <= 1'b0;
		else if (psel && penable && pwrite && pready &&
			paddr == tid_pkg::ADDR_TRANSPARENT_BLACK)
			transparent_black_q <= pwdata[0];
	end

	assign accept = src_valid && src_ready;

	tid_parser #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.PAW(PAW)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(src_data),
		.job(job),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	tid_expander #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.PAW(PAW)
	) u_expander (
		.clk(clk),
		.arst_n(arst_n),
		.transparent_black(transparent_black_q),
		.job(job),
		.job_ready(src_ready),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix_data(pix_data)
	);

endmodule

[verif/tim_pixel_checker.sv]
// Checker for the TIM image pixel decoder: decodes accepted words and compares pixels.
`timescale 1ns / 100ps

module tim_pixel_checker #(
	parameter int PAL_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              src_valid,
	input  logic              src_ready,
	input  tid_pkg::in_item_t src_data,
	input  logic              pix_valid,
	input  logic              pix_ready,
	input  tid_pkg::pixel_t   pix_data,
	input  logic              end_of_run,
	output int                fail_count,
	output int                pixels_owed
);

	typedef enum logic [3:0] {
		AWAIT_START,
		IN_MAGIC,
		IN_TYPE,
		IN_CLUT_HEAD,
		IN_CLUT,
		IN_SIZE,
		IN_IMAGE_HEAD,
		IN_PIXELS,
		PAST_END
	} parse_t;

	parse_t          phase;
	logic [3:0]      hdr_cnt;
	tid_pkg::kind_t  kind;
	logic [15:0]     clut_total;
	logic [15:0]     clut_idx;
	logic [15:0]     row_len;
	logic [31:0]     words_left;
	logic [15:0]     type_lo;
	logic            transp_black;
	logic [15:0]     palette [0:PAL_DEPTH-1];
	tid_pkg::pixel_t pending_pixels[$];
	tid_pkg::pixel_t head_px;

	initial fail_count = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR at %0t ns: %s: got %0h, wanted %0h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic logic [15:0] clut_colour(input int unsigned idx);
		return (idx < PAL_DEPTH) ? palette[idx] : 16'h0000;
	endfunction

	function automatic tid_pkg::pixel_t to_rgba(input logic [15:0] c, input logic run_end,
			input logic img_end);
		tid_pkg::pixel_t p;
		p.red   = {c[4:0], 3'b000};
		p.green = {c[9:5], 3'b000};
		p.blue  = {c[14:10], 3'b000};
		// Pure zero is always see-through; the register extends this to 0x8000.
		if (c == 16'h0000 || (transp_black && (c[14:0] & tid_pkg::COLOUR_MASK) == 15'd0))
			p.alpha = 8'h00;
		else
			p.alpha = tid_pkg::ALPHA_OPAQUE;
		p.last_of_run   = run_end;
		p.last_of_image = img_end;
		return p;
	endfunction

	// Advances the parse by one word and queues the pixels that word yields.
	task automatic decode_word(input tid_pkg::in_item_t it);
		logic img_end;
		if (it.start_of_file) begin
			phase      = IN_MAGIC;
			hdr_cnt    = 4'd1;
			kind       = tid_pkg::KIND_NONE;
			clut_total = '0;
			clut_idx   = '0;
			row_len    = '0;
			words_left = '0;
		end else begin
			case (phase)
				IN_MAGIC: begin
					phase   = IN_TYPE;
					hdr_cnt = 4'd0;
				end
				IN_TYPE: begin
					if (hdr_cnt == 4'd0) begin
						type_lo = it.word;
						hdr_cnt = 4'd1;
					end else begin
						hdr_cnt = 4'd0;
						case ({it.word, type_lo})
							tid_pkg::TYPE_DIRECT: begin
								kind  = tid_pkg::KIND_16;
								phase = IN_SIZE;
							end
							tid_pkg::TYPE_8BPP: begin
								kind  = tid_pkg::KIND_8;
								phase = IN_CLUT_HEAD;
							end
							tid_pkg::TYPE_4BPP: begin
								kind  = tid_pkg::KIND_4;
								phase = IN_CLUT_HEAD;
							end
							default: begin
								kind  = tid_pkg::KIND_NONE;
								phase = IN_SIZE;
							end
						endcase
					end
				end
				IN_CLUT_HEAD: begin
					// The fifth header word is the row width, i.e. the entry count.
					if (hdr_cnt == 4'd4)
						clut_total = it.word;
					if (hdr_cnt == 4'd5) begin
						hdr_cnt  = 4'd0;
						clut_idx = '0;
						phase    = (clut_total == 16'd0) ? IN_SIZE : IN_CLUT;
					end else begin
						hdr_cnt = hdr_cnt + 4'd1;
					end
				end
				IN_CLUT: begin
					if (clut_idx < PAL_DEPTH)
						palette[clut_idx] = it.word;
					clut_idx = clut_idx + 16'd1;
					if (clut_idx >= clut_total) begin
						phase   = IN_SIZE;
						hdr_cnt = 4'd0;
					end
				end
				IN_SIZE: begin
					if (hdr_cnt == 4'd0) begin
						hdr_cnt = 4'd1;
					end else begin
						hdr_cnt = 4'd0;
						phase   = IN_IMAGE_HEAD;
					end
				end
				IN_IMAGE_HEAD: begin
					if (hdr_cnt == 4'd2)
						row_len = it.word;
					if (hdr_cnt == 4'd3) begin
						hdr_cnt    = 4'd0;
						words_left = 32'(row_len) * 32'(it.word);
						if (kind == tid_pkg::KIND_NONE || words_left == 32'd0)
							phase = PAST_END;
						else
							phase = IN_PIXELS;
					end else begin
						hdr_cnt = hdr_cnt + 4'd1;
					end
				end
				IN_PIXELS: begin
					img_end    = (words_left <= 32'd1);
					words_left = img_end ? 32'd0 : words_left - 32'd1;
					if (img_end)
						phase = PAST_END;
					case (kind)
						tid_pkg::KIND_16:
							pending_pixels.push_back(to_rgba(it.word, 1'b1, img_end));
						tid_pkg::KIND_8: begin
							pending_pixels.push_back(to_rgba(clut_colour(it.word[7:0]),
								1'b0, 1'b0));
							pending_pixels.push_back(to_rgba(clut_colour(it.word[15:8]),
								1'b1, img_end));
						end
						tid_pkg::KIND_4: begin
							pending_pixels.push_back(to_rgba(clut_colour(it.word[3:0]),
								1'b0, 1'b0));
							pending_pixels.push_back(to_rgba(clut_colour(it.word[7:4]),
								1'b0, 1'b0));
							pending_pixels.push_back(to_rgba(clut_colour(it.word[11:8]),
								1'b0, 1'b0));
							pending_pixels.push_back(to_rgba(clut_colour(it.word[15:12]),
								1'b1, img_end));
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase        = AWAIT_START;
			hdr_cnt      = '0;
			kind         = tid_pkg::KIND_NONE;
			clut_total   = '0;
			clut_idx     = '0;
			row_len      = '0;
			words_left   = '0;
			type_lo      = '0;
			transp_black = 1'b0;
			pending_pixels.delete();
		end else begin
			if (psel && penable && pwrite && pready &&
				paddr == tid_pkg::ADDR_TRANSPARENT_BLACK)
				transp_black = pwdata[0];
			if (pix_valid && pix_ready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch("pixel with none outstanding",
						{pix_data.red, pix_data.green, pix_data.blue, pix_data.alpha}, '0);
				end else begin
					head_px = pending_pixels.pop_front();
					if (pix_data.red != head_px.red)
						report_mismatch("red", pix_data.red, head_px.red);
					if (pix_data.green != head_px.green)
						report_mismatch("green", pix_data.green, head_px.green);
					if (pix_data.blue != head_px.blue)
						report_mismatch("blue", pix_data.blue, head_px.blue);
					if (pix_data.alpha != head_px.alpha)
						report_mismatch("alpha", pix_data.alpha, head_px.alpha);
					if (pix_data.last_of_run != head_px.last_of_run)
						report_mismatch("last_of_run", pix_data.last_of_run,
							head_px.last_of_run);
					if (pix_data.last_of_image != head_px.last_of_image)
						report_mismatch("last_of_image", pix_data.last_of_image,
							head_px.last_of_image);
				end
			end
			if (src_valid && src_ready)
				decode_word(src_data);
		end
		pixels_owed = pending_pixels.size();
	end

	always @(posedge end_of_run) begin
		if (pending_pixels.size() != 0)
			report_mismatch("pixels never produced", pending_pixels.size(), 0);
	end

endmodule

[verif/tb_tim_image_pixel_decoder.sv]
// Testbench top for the TIM image pixel decoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_tim_image_pixel_decoder;

	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PAL_DEPTH     = 256;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              psel       = 1'b0;
	logic              penable    = 1'b0;
	logic              pwrite     = 1'b0;
	logic [2:0]        paddr      = '0;
	logic [31:0]       pwdata     = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              src_valid  = 1'b0;
	logic              src_ready;
	tid_pkg::in_item_t src_data   = '0;
	logic              pix_valid;
	logic              pix_ready  = 1'b0;
	tid_pkg::pixel_t   pix_data;
	logic              end_of_run = 1'b0;
	int                fail_count;
	int                pixels_owed;

	bit          quiet      = 1'b0;
	bit          hold_req   = 1'b0;
	int          words_sent = 0;
	int          pal_filled = 0;
	logic [15:0] clut_words[$];
	logic [15:0] pix_words[$];

	tim_image_pixel_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data)
	);

	tim_pixel_checker u_pixel_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.src_data    (src_data),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix_data    (pix_data),
		.end_of_run  (end_of_run),
		.fail_count  (fail_count),
		.pixels_owed (pixels_owed)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#200_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Pixel receiver: short random stalls, and one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pix_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
				pix_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pix_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				pix_ready <= 1'b1;
			end else begin
				pix_ready <= 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic push_word(input logic [15:0] w, input logic sof);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= '{word: w, start_of_file: sof};
		@(posedge clk);
		while (!src_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stops offering words, then waits until every pixel has come out.
	task automatic settle();
		src_valid <= 1'b0;
		while (pixels_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Colours lean towards the values that matter for transparency.
	function automatic logic [15:0] any_colour();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Index words only point at palette entries that have been written.
	function automatic logic [15:0] index_word(input logic [31:0] ftype, input int fill);
		logic [15:0] w;
		int lim;
		int k;
		w = '0;
		if (ftype == tid_pkg::TYPE_8BPP) begin
			lim = (fill < 1) ? 1 : fill;
			w[7:0]  = 8'($urandom_range(0, lim - 1));
			w[15:8] = 8'($urandom_range(0, lim - 1));
		end else begin
			lim = (fill < 16) ? fill : 16;
			lim = (lim < 1) ? 1 : lim;
			for (k = 0; k < 4; k++) w[4*k +: 4] = 4'($urandom_range(0, lim - 1));
		end
		return w;
	endfunction

	// Builds one file and sends its first keep words (all of them when keep is negative).
	task automatic send_file(input logic [31:0] ftype, input int clut_n, input int cols,
			input int rows, input int keep, input int trailer);
		logic [15:0] w[$];
		int i;
		int n;
		int fill;
		int sent;
		bit indexed;
		indexed = (ftype == tid_pkg::TYPE_8BPP || ftype == tid_pkg::TYPE_4BPP);
		fill = (clut_n < PAL_DEPTH) ? clut_n : PAL_DEPTH;
		if (fill < pal_filled)
			fill = pal_filled;
		w.push_back(16'($urandom));
		w.push_back(16'($urandom));
		w.push_back(ftype[15:0]);
		w.push_back(ftype[31:16]);
		if (indexed) begin
			// Block length, x, y, width (entry count), height.
			for (i = 0; i < 4; i++) w.push_back(16'($urandom));
			w.push_back(16'(clut_n));
			w.push_back(16'($urandom));
			for (i = 0; i < clut_n; i++)
				w.push_back(clut_words.size() != 0 ? clut_words.pop_front() : any_colour());
		end
		// Data size and skip x / skip y carry nothing the decoder uses.
		for (i = 0; i < 4; i++) w.push_back(16'($urandom));
		w.push_back(16'(cols));
		w.push_back(16'(rows));
		for (i = 0; i < cols * rows + trailer; i++) begin
			if (pix_words.size() != 0)
				w.push_back(pix_words.pop_front());
			else if (ftype == tid_pkg::TYPE_DIRECT)
				w.push_back(any_colour());
			else if (indexed)
				w.push_back(index_word(ftype, fill));
			else
				w.push_back(16'($urandom));
		end
		clut_words.delete();
		pix_words.delete();
		n = (keep >= 0 && keep < w.size()) ? keep : w.size();
		for (i = 0; i < n; i++) push_word(w[i], i == 0);
		if (indexed) begin
			// Colour-table entries follow the ten words of file and table header.
			sent = n - 10;
			if (sent > clut_n)
				sent = clut_n;
			if (sent > PAL_DEPTH)
				sent = PAL_DEPTH;
			if (sent > pal_filled)
				pal_filled = sent;
		end
		words_sent += n;
	endtask

	// Mostly well-formed files of random shape; some are cut short by the next start.
	task automatic random_files(input int budget);
		logic [31:0] ftype;
		int goal;
		int cols;
		int rows;
		goal = words_sent + budget;
		while (words_sent < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2: ftype = tid_pkg::TYPE_DIRECT;
				3, 4, 5: ftype = tid_pkg::TYPE_8BPP;
				6, 7, 8: ftype = tid_pkg::TYPE_4BPP;
				default: ftype = {16'($urandom_range(0, 1)), 16'($urandom)};
			endcase
			cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
			rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
			send_file(ftype, $urandom_range(0, 6), cols, rows,
				($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : -1,
				$urandom_range(0, 1));
		end
	endtask

	initial begin
		int waited;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		reg_write(tid_pkg::ADDR_TRANSPARENT_BLACK, 32'd0);

		// Stray words before any start of file are ignored.
		push_word(16'hffff, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'ha5a5, 1'b0);

		// Direct colour at the extremes, then a word past the end of the image.
		pix_words = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff};
		send_file(tid_pkg::TYPE_DIRECT, 0, 2, 2, -1, 1);

		// A full sixteen-entry table, so that every 4-bit index lands on a written entry.
		clut_words = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff};
		pix_words  = '{16'hfedc, 16'h3210};
		send_file(tid_pkg::TYPE_4BPP, 16, 2, 1, -1, 0);

		// An empty colour table leaves the palette as it was.
		pix_words = '{16'h0100, 16'h0f0e};
		send_file(tid_pkg::TYPE_8BPP, 0, 2, 1, -1, 0);

		// Unknown type: the header is parsed and the data words dropped.
		send_file(32'h0001_0002, 0, 1, 1, -1, 0);

		// Empty image.
		send_file(tid_pkg::TYPE_DIRECT, 0, 0, 2, -1, 1);

		// Files abandoned part way through the colour table and through the data.
		send_file(tid_pkg::TYPE_4BPP, 4, 2, 2, 12, 0);
		send_file(tid_pkg::TYPE_DIRECT, 0, 2, 2, 13, 0);

		settle();
		reg_write(tid_pkg::ADDR_TRANSPARENT_BLACK, 32'd1);
		pix_words = '{16'h8000, 16'h0000, 16'hffff, 16'h7fff};
		send_file(tid_pkg::TYPE_DIRECT, 0, 4, 1, -1, 0);

		// The receiver holds off while a 4-bit image keeps arriving.
		hold_req = 1'b1;
		send_file(tid_pkg::TYPE_4BPP, 0, 4, 3, -1, 0);

		settle();
		reg_write(tid_pkg::ADDR_TRANSPARENT_BLACK, 32'd0);
		quiet = 1'b1;
		random_files(30);
		src_valid <= 1'b0;

		waited = 0;
		while (pixels_owed != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		end_of_run <= 1'b1;
		@(negedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
